### hw/rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list table package
// Shared constants, command and status codes, and the control word that the
// top level sends along the row of cells.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
        logic clr_en;
    } cell_ctrl_t;

endpackage

### hw/rtl/slt_cell.sv
// ----------------------------------------------------------------------------
// Sorted list table cell
// Holds one entry and its occupancy, compares it with the search value and
// takes a new entry from the command, the left neighbour or the right one.
// ----------------------------------------------------------------------------
module slt_cell #(
    parameter int VALUE_WIDTH = slt_pkg::DEF_VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  slt_pkg::cell_ctrl_t    ctrl,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [VALUE_WIDTH-1:0] left_entry,
    input  logic                   left_valid,
    input  logic                   left_lt,
    input  logic [VALUE_WIDTH-1:0] right_entry,
    input  logic                   right_valid,
    output logic [VALUE_WIDTH-1:0] entry,
    output logic                   valid,
    output logic                   lt,
    output logic                   hit
);

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   lt_reg;
    logic                   eq_reg;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.clr_en)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.ins_en && !lt_reg)
        begin
            if (left_lt)
            begin
                entry_next = value;
                valid_next = 1'b1;
            end
            else
            begin
                entry_next = left_entry;
                valid_next = left_valid;
            end
        end
        else if (ctrl.del_en && !lt_reg)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.cmp_en)
            begin
                lt_reg <= valid_reg && (entry_reg < value);
                eq_reg <= valid_reg && (entry_reg == value);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign hit   = eq_reg && left_lt;

endmodule

### hw/rtl/sorted_list_table_top.sv
// ----------------------------------------------------------------------------
// Sorted list table
// Ascending multiset of up to CAPACITY values kept in a row of cells, with
// insert, delete, search and clear commands and one result item per command.
// ----------------------------------------------------------------------------
// An item is taken when the block is idle. It then passes through a compare
// state in which every cell compares its entry with the value, an update state
// in which the cells whose entries are not below the value shift or load
// together (or all cells clear), and a result state that gathers the smallest
// and largest entries into the output register, waiting there while the output
// is stalled; no new item is taken before then. The latency does not depend on
// CAPACITY. A new item is accepted while the previous result still waits to be taken.
module sorted_list_table_top #(
    parameter int CAPACITY    = slt_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = slt_pkg::DEF_VALUE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // value [31:0]
    input  logic [slt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd [1:0]
    input  logic [slt_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status [1:0], found [2], entry_count [9:3], is_empty [10],
    // smallest [42:11], largest [74:43], zero [79:75]
    output logic [slt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_RES  = 4'b1000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    slt_pkg::cmd_t           cmd_reg;
    logic [VALUE_WIDTH-1:0]  value_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    slt_pkg::status_t        status_reg;
    slt_pkg::status_t        status_next;
    logic                    found_reg;
    logic                    found_next;
    logic                    out_valid_reg;
    logic [slt_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [63:0]             value_ext;
    slt_pkg::cell_ctrl_t     ctrl;
    logic [VALUE_WIDTH-1:0]  entry_w [CAPACITY];
    logic [CAPACITY:0]       valid_w;
    logic [CAPACITY-1:0]     lt_w;
    logic [CAPACITY-1:0]     hit_w;
    logic                    any_hit;
    logic                    is_full;
    logic                    is_zero;
    logic [VALUE_WIDTH-1:0]  largest_w;
    logic [63:0]             smallest_ext;
    logic [63:0]             largest_ext;
    logic [15:0]             count_ext;
    logic                    in_fire;
    logic                    res_load;

    assign value_ext = 64'(s_axis_tdata);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign res_load  = (state_reg == S_RES) && (!out_valid_reg || m_axis_tready);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_zero   = (count_reg == '0);
    assign any_hit   = |hit_w;
    assign valid_w[CAPACITY] = 1'b0;

    always_comb
    begin
        ctrl.cmp_en = (state_reg == S_CMP);
        ctrl.ins_en = (state_reg == S_UPD) && (cmd_reg == slt_pkg::CMD_INSERT) && !is_full;
        ctrl.del_en = (state_reg == S_UPD) && (cmd_reg == slt_pkg::CMD_DELETE) && any_hit;
        ctrl.clr_en = (state_reg == S_UPD) && (cmd_reg == slt_pkg::CMD_CLEAR);
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_entry;
        logic                   left_valid;
        logic                   left_lt;
        logic [VALUE_WIDTH-1:0] right_entry;

        if (i == 0)
        begin : g_first
            assign left_entry = value_reg;
            assign left_valid = 1'b1;
            assign left_lt    = 1'b1;
        end
        else
        begin : g_inner
            assign left_entry = entry_w[i-1];
            assign left_valid = valid_w[i-1];
            assign left_lt    = lt_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = entry_w[i];
        end
        else
        begin : g_mid
            assign right_entry = entry_w[i+1];
        end

        slt_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .value       (value_reg),
            .left_entry  (left_entry),
            .left_valid  (left_valid),
            .left_lt     (left_lt),
            .right_entry (right_entry),
            .right_valid (valid_w[i+1]),
            .entry       (entry_w[i]),
            .valid       (valid_w[i]),
            .lt          (lt_w[i]),
            .hit         (hit_w[i])
        );
    end

    always_comb
    begin
        largest_w = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (valid_w[i] && !valid_w[i+1])
            begin
                largest_w = largest_w | entry_w[i];
            end
        end
    end

    assign smallest_ext = is_zero ? 64'd0 : 64'(entry_w[0]);
    assign largest_ext  = 64'(largest_w);
    assign count_ext    = 16'(count_reg);

    always_comb
    begin
        status_next = slt_pkg::ST_OK;
        found_next  = 1'b0;
        count_next  = count_reg;
        unique case (cmd_reg)
            slt_pkg::CMD_INSERT:
            begin
                found_next = any_hit;
                if (is_full)
                begin
                    status_next = slt_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            slt_pkg::CMD_DELETE:
            begin
                priority if (is_zero)
                begin
                    status_next = slt_pkg::ST_EMPTY;
                end
                else if (!any_hit)
                begin
                    status_next = slt_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    found_next = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            slt_pkg::CMD_SEARCH:
            begin
                priority if (is_zero)
                begin
                    status_next = slt_pkg::ST_EMPTY;
                end
                else if (!any_hit)
                begin
                    status_next = slt_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    found_next = 1'b1;
                end
            end
            slt_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                state_next = S_RES;
            end
            S_RES:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_UPD)
            begin
                count_reg <= count_next;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= slt_pkg::cmd_t'(s_axis_tuser);
            value_reg <= value_ext[VALUE_WIDTH-1:0];
        end
        if (state_reg == S_UPD)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
        end
        if (res_load)
        begin
            out_data_reg <= {5'd0, largest_ext[31:0], smallest_ext[31:0], is_zero,
                             count_ext[6:0], found_reg, status_reg};
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_head_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        valid_w[0] == !is_zero)
        else $error("first cell occupancy disagrees with entry count");

    a_tail_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        valid_w[CAPACITY-1] == is_full)
        else $error("last cell occupancy disagrees with entry count");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_w))
        else $error("more than one cell matches as first equal entry");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_UPD) |=> $stable(count_reg))
        else $error("entry count changed outside the update cycle");
`endif

endmodule

### verif/sorted_list_table_checker.sv
// ----------------------------------------------------------------------------
// Sorted list table checker
// Watches both stream channels of the sorted list table. Each accepted
// command item is applied to a local copy of the table, and the report this
// yields is queued. Each accepted result item is compared field by field with
// the oldest queued report.
// ----------------------------------------------------------------------------
module sorted_list_table_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [slt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [slt_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [slt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                             reports_outstanding,
    output int                             error_count
);

    import slt_pkg::*;

    localparam int CAPACITY = DEF_CAPACITY;

    typedef struct {
        status_t     status;
        logic        found;
        logic [6:0]  entry_count;
        logic        is_empty;
        logic [31:0] smallest;
        logic [31:0] largest;
    } table_report_t;

    logic [31:0]   entries [CAPACITY];
    int            stored;
    table_report_t outstanding_reports [$];

    function automatic table_report_t apply_command(cmd_t cmd, logic [31:0] value);
        table_report_t rep;
        int            pos;
        logic          hit;
        rep.status = ST_OK;
        rep.found  = 1'b0;
        pos = 0;
        while (pos < stored && entries[pos] < value)
            pos++;
        hit = (pos < stored) && (entries[pos] == value);
        case (cmd)
            CMD_INSERT:
            begin
                rep.found = hit;
                if (stored >= CAPACITY)
                    rep.status = ST_FULL;
                else
                begin
                    for (int i = stored; i > pos; i--)
                        entries[i] = entries[i - 1];
                    entries[pos] = value;
                    stored++;
                end
            end
            CMD_DELETE:
            begin
                if (stored == 0)
                    rep.status = ST_EMPTY;
                else if (!hit)
                    rep.status = ST_NOT_FOUND;
                else
                begin
                    rep.found = 1'b1;
                    for (int i = pos; i < stored - 1; i++)
                        entries[i] = entries[i + 1];
                    stored--;
                end
            end
            CMD_SEARCH:
            begin
                if (stored == 0)
                    rep.status = ST_EMPTY;
                else if (!hit)
                    rep.status = ST_NOT_FOUND;
                else
                    rep.found = 1'b1;
            end
            default:
                stored = 0;
        endcase
        rep.entry_count = 7'(stored);
        rep.is_empty    = (stored == 0);
        rep.smallest    = (stored == 0) ? 32'd0 : entries[0];
        rep.largest     = (stored == 0) ? 32'd0 : entries[stored - 1];
        return rep;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    initial
        error_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        table_report_t want;
        if (!rst_n)
        begin
            stored = 0;
            outstanding_reports.delete();
            reports_outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (outstanding_reports.size() == 0)
                begin
                    $display("%0t: result item with none outstanding, expected none, actual %0h",
                             $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = outstanding_reports.pop_front();
                    compare_field("status", want.status, m_axis_tdata[1:0]);
                    compare_field("found", want.found, m_axis_tdata[2]);
                    compare_field("entry_count", want.entry_count, m_axis_tdata[9:3]);
                    compare_field("is_empty", want.is_empty, m_axis_tdata[10]);
                    compare_field("smallest", want.smallest, m_axis_tdata[42:11]);
                    compare_field("largest", want.largest, m_axis_tdata[74:43]);
                    compare_field("padding", 32'd0, m_axis_tdata[79:75]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                outstanding_reports.push_back(apply_command(cmd_t'(s_axis_tuser), s_axis_tdata));
            reports_outstanding <= outstanding_reports.size();
        end
    end

endmodule

### verif/sorted_list_table_top_test.sv
// ----------------------------------------------------------------------------
// Sorted list table test
// Drives insert, delete, search and clear items into the sorted list table:
// a short directed opening, then segments of random traffic that fill, drain,
// mix or disturb the table, with random gaps on both channels and one long
// output stall. A separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module sorted_list_table_top_test;

    import slt_pkg::*;

    localparam int ITEM_TARGET = 900;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED,
        MODE_NOISE
    } traffic_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic        rx_ready;
    logic        out_hold;
    logic        tx_quiet;
    int          items_sent;
    int          cycle_count;
    int          reports_outstanding;
    int          error_count;
    logic [31:0] recent_values [16];
    int          recent_next;

    assign m_axis_tready = rx_ready && !out_hold;

    sorted_list_table_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sorted_list_table_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tuser        (s_axis_tuser),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .reports_outstanding (reports_outstanding),
        .error_count         (error_count)
    );

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 32'($urandom_range(0, 40));
            5:             return 32'hFFFF_FFFF - 32'($urandom_range(0, 7));
            6, 7:          return $urandom;
            default:       return recent_values[$urandom_range(0, 15)];
        endcase
    endfunction

    function automatic cmd_t pick_command(traffic_mode_t mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                return (roll < 92) ? CMD_INSERT : (roll < 96) ? CMD_SEARCH : CMD_DELETE;
            MODE_DRAIN:
                return (roll < 65) ? CMD_DELETE : (roll < 90) ? CMD_SEARCH : CMD_INSERT;
            MODE_MIXED:
                return (roll < 40) ? CMD_INSERT : (roll < 70) ? CMD_DELETE :
                       (roll < 99) ? CMD_SEARCH : CMD_CLEAR;
            default:
                return cmd_t'(roll % 4);
        endcase
    endfunction

    task automatic send_item(cmd_t cmd, logic [31:0] value);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (cmd == CMD_INSERT)
        begin
            recent_values[recent_next] = value;
            recent_next = (recent_next + 1) % 16;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        traffic_mode_t mode;
        int            length;
        logic [31:0]   value;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        tx_quiet      = 1'b0;
        items_sent    = 0;
        recent_next   = 0;
        foreach (recent_values[i])
            recent_values[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_SEARCH, 32'd5);
        send_item(CMD_DELETE, 32'd5);
        send_item(CMD_INSERT, 32'd0);
        send_item(CMD_INSERT, 32'hFFFF_FFFF);
        send_item(CMD_INSERT, 32'd100);
        send_item(CMD_INSERT, 32'd100);
        send_item(CMD_SEARCH, 32'd100);
        send_item(CMD_SEARCH, 32'd7);
        send_item(CMD_DELETE, 32'd7);
        send_item(CMD_DELETE, 32'd100);
        send_item(CMD_SEARCH, 32'd100);
        send_item(CMD_DELETE, 32'd100);
        send_item(CMD_INSERT, 32'h8000_0000);
        send_item(CMD_INSERT, 32'h7FFF_FFFF);
        send_item(CMD_SEARCH, 32'd0);
        send_item(CMD_DELETE, 32'd0);
        send_item(CMD_DELETE, 32'hFFFF_FFFF);
        send_item(CMD_CLEAR, $urandom);
        send_item(CMD_SEARCH, 32'd0);
        send_item(CMD_INSERT, 32'hA5A5_A5A5);
        send_item(CMD_CLEAR, 32'hFFFF_FFFF);

        // The first segment fills the table well past its capacity.
        mode   = MODE_FILL;
        length = 100;
        while (items_sent < ITEM_TARGET)
        begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            repeat (length)
            begin
                value = (mode == MODE_NOISE && $urandom_range(0, 1) == 0) ? $urandom
                                                                          : pick_value();
                send_item(pick_command(mode), value);
            end
            mode   = traffic_mode_t'($urandom_range(0, 3));
            length = $urandom_range(20, 80);
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (reports_outstanding != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int   gap;
        int   taken;
        logic rx_quiet;
        rx_ready = 1'b0;
        taken    = 0;
        rx_quiet = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = rx_quiet ? 0 : $urandom_range(0, 15);
            if (gap != 0)
            begin
                rx_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rx_ready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge clk);
            taken++;
            if (taken % 40 == 0)
                rx_quiet = ($urandom_range(0, 2) == 0);
        end
    end

    // A long output stall while the sender keeps offering items.
    initial
    begin
        out_hold = 1'b0;
        wait (items_sent >= 300);
        @(posedge clk);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
hw/rtl/slt_pkg.sv
hw/rtl/slt_cell.sv
hw/rtl/sorted_list_table_top.sv
verif/sorted_list_table_checker.sv
verif/sorted_list_table_top_test.sv
